/* design/ricd_pkg.sv */
// ============================================================================
// ricd_pkg
// Shared constants and opcode lookup functions for the instruction class
// decoder.
// ============================================================================
package ricd_pkg;

   localparam int unsigned InstrWidth = 32;
   localparam int unsigned ClassWidth = 8;

   // Primary opcodes that select an extended group.
   localparam logic [5:0] OP_G19 = 6'd19;
   localparam logic [5:0] OP_G30 = 6'd30;
   localparam logic [5:0] OP_G31 = 6'd31;
   localparam logic [5:0] OP_G58 = 6'd58;
   localparam logic [5:0] OP_G62 = 6'd62;

   // Class code bases.
   localparam logic [7:0] CLS_INVALID   = 8'd0;
   localparam logic [7:0] CLS_G19_BASE  = 8'd14;
   localparam logic [7:0] CLS_RLD_BASE  = 8'd36;
   localparam logic [7:0] CLS_DCBT      = 8'd42;
   localparam logic [7:0] CLS_G31A_BASE = 8'd43;
   localparam logic [7:0] CLS_G31B_BASE = 8'd137;
   localparam logic [7:0] CLS_SRADIX    = 8'd158;
   localparam logic [7:0] CLS_G58_BASE  = 8'd173;
   localparam logic [7:0] CLS_G62_BASE  = 8'd176;

   // Extended opcodes with special handling in group 31.
   localparam logic [9:0] XO_DCBT     = 10'd278;
   localparam logic [9:0] XO_DCBT_ALT = 10'd246;
   localparam logic [8:0] XO_SRADIX   = 9'd413;

   // Primary opcode table.
   function automatic logic [7:0] primary_class(input logic [5:0] op);
      logic [7:0] c;
      case (op)
         6'd2:  c = 8'd1;   6'd3:  c = 8'd2;   6'd7:  c = 8'd3;
         6'd8:  c = 8'd4;   6'd10: c = 8'd5;   6'd11: c = 8'd6;
         6'd12: c = 8'd7;   6'd13: c = 8'd8;   6'd14: c = 8'd9;
         6'd15: c = 8'd10;  6'd16: c = 8'd11;  6'd17: c = 8'd12;
         6'd18: c = 8'd13;  6'd20: c = 8'd27;  6'd21: c = 8'd28;
         6'd23: c = 8'd29;  6'd24: c = 8'd30;  6'd25: c = 8'd31;
         6'd26: c = 8'd32;  6'd27: c = 8'd33;  6'd28: c = 8'd34;
         6'd29: c = 8'd35;
         6'd32: c = 8'd159; 6'd33: c = 8'd160; 6'd34: c = 8'd161;
         6'd35: c = 8'd162; 6'd36: c = 8'd163; 6'd37: c = 8'd164;
         6'd38: c = 8'd165; 6'd39: c = 8'd166; 6'd40: c = 8'd167;
         6'd41: c = 8'd168; 6'd42: c = 8'd169; 6'd43: c = 8'd170;
         6'd44: c = 8'd171; 6'd45: c = 8'd172;
         default: c = CLS_INVALID;
      endcase
      return c;
   endfunction

   // Group 19 extended opcode table; returns offset from the group base plus one, zero on miss.
   function automatic logic [7:0] g19_index(input logic [9:0] xo);
      logic [7:0] c;
      case (xo)
         10'd0:   c = 8'd1;  10'd16:  c = 8'd2;  10'd18:  c = 8'd3;
         10'd33:  c = 8'd4;  10'd129: c = 8'd5;  10'd150: c = 8'd6;
         10'd193: c = 8'd7;  10'd225: c = 8'd8;  10'd257: c = 8'd9;
         10'd289: c = 8'd10; 10'd417: c = 8'd11; 10'd449: c = 8'd12;
         10'd528: c = 8'd13;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   // Group 31 first table; returns index plus one, zero on miss.
   function automatic logic [6:0] g31a_index(input logic [9:0] xo);
      logic [6:0] c;
      case (xo)
         10'd0: c = 7'd1;     10'd4: c = 7'd2;     10'd19: c = 7'd3;
         10'd20: c = 7'd4;    10'd21: c = 7'd5;    10'd23: c = 7'd6;
         10'd24: c = 7'd7;    10'd26: c = 7'd8;    10'd27: c = 7'd9;
         10'd28: c = 7'd10;   10'd32: c = 7'd11;   10'd53: c = 7'd12;
         10'd54: c = 7'd13;   10'd55: c = 7'd14;   10'd58: c = 7'd15;
         10'd60: c = 7'd16;   10'd68: c = 7'd17;   10'd83: c = 7'd18;
         10'd84: c = 7'd19;   10'd86: c = 7'd20;   10'd87: c = 7'd21;
         10'd119: c = 7'd22;  10'd124: c = 7'd23;  10'd144: c = 7'd24;
         10'd146: c = 7'd25;  10'd149: c = 7'd26;  10'd150: c = 7'd27;
         10'd151: c = 7'd28;  10'd178: c = 7'd29;  10'd181: c = 7'd30;
         10'd183: c = 7'd31;  10'd210: c = 7'd32;  10'd214: c = 7'd33;
         10'd215: c = 7'd34;  10'd242: c = 7'd35;  10'd247: c = 7'd36;
         10'd279: c = 7'd37;  10'd284: c = 7'd38;  10'd274: c = 7'd39;
         10'd306: c = 7'd40;  10'd310: c = 7'd41;  10'd311: c = 7'd42;
         10'd316: c = 7'd43;  10'd339: c = 7'd44;  10'd341: c = 7'd45;
         10'd343: c = 7'd46;  10'd370: c = 7'd47;  10'd371: c = 7'd48;
         10'd373: c = 7'd49;  10'd375: c = 7'd50;  10'd407: c = 7'd51;
         10'd412: c = 7'd52;  10'd434: c = 7'd53;  10'd438: c = 7'd54;
         10'd439: c = 7'd55;  10'd444: c = 7'd56;  10'd467: c = 7'd57;
         10'd476: c = 7'd58;  10'd498: c = 7'd59;  10'd533: c = 7'd60;
         10'd534: c = 7'd61;  10'd535: c = 7'd62;  10'd536: c = 7'd63;
         10'd539: c = 7'd64;  10'd566: c = 7'd65;  10'd567: c = 7'd66;
         10'd595: c = 7'd67;  10'd597: c = 7'd68;  10'd598: c = 7'd69;
         10'd599: c = 7'd70;  10'd631: c = 7'd71;  10'd569: c = 7'd72;
         10'd915: c = 7'd73;  10'd851: c = 7'd74;  10'd402: c = 7'd75;
         10'd661: c = 7'd76;  10'd662: c = 7'd77;  10'd663: c = 7'd78;
         10'd695: c = 7'd79;  10'd725: c = 7'd80;  10'd727: c = 7'd81;
         10'd759: c = 7'd82;  10'd790: c = 7'd83;  10'd762: c = 7'd84;
         10'd794: c = 7'd85;  10'd824: c = 7'd86;  10'd854: c = 7'd87;
         10'd918: c = 7'd88;  10'd922: c = 7'd89;  10'd954: c = 7'd90;
         10'd982: c = 7'd91;  10'd983: c = 7'd92;  10'd986: c = 7'd93;
         10'd1014: c = 7'd94;
         default: c = 7'd0;
      endcase
      return c;
   endfunction

   // Group 31 second table on bits 22-30; index plus one, zero on miss.
   function automatic logic [4:0] g31b_index(input logic [8:0] xo);
      logic [4:0] c;
      case (xo)
         9'd8: c = 5'd1;     9'd9: c = 5'd2;     9'd10: c = 5'd3;
         9'd11: c = 5'd4;    9'd40: c = 5'd5;    9'd73: c = 5'd6;
         9'd75: c = 5'd7;    9'd104: c = 5'd8;   9'd136: c = 5'd9;
         9'd138: c = 5'd10;  9'd200: c = 5'd11;  9'd202: c = 5'd12;
         9'd232: c = 5'd13;  9'd233: c = 5'd14;  9'd234: c = 5'd15;
         9'd235: c = 5'd16;  9'd266: c = 5'd17;  9'd457: c = 5'd18;
         9'd459: c = 5'd19;  9'd489: c = 5'd20;  9'd491: c = 5'd21;
         default: c = 5'd0;
      endcase
      return c;
   endfunction

endpackage

/* design/risc_instruction_class_decoder_core.sv */
// ============================================================================
// risc_instruction_class_decoder_core
// Decodes a 32-bit instruction word into a dense instruction class code.
// ============================================================================
// Throughput: one request per cycle; a stall at the output holds every stage.
// The pipeline depth is set by three registered stages: field extract and
// table lookup, group selection, and the output register.
// Reset clears all stage valid bits; payload registers are not reset.
module risc_instruction_class_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_instr_class,
   output logic        rsp_is_invalid
);

   // Stage 1 holds raw lookup results per group.
   typedef struct packed {
      logic [5:0] op;
      logic [7:0] prim;
      logic [7:0] g19;
      logic [2:0] rld_lo;
      logic [3:0] rld_hi;
      logic       dcbt;
      logic [6:0] g31a;
      logic [4:0] g31b;
      logic       sradix;
      logic [1:0] low2;
   } s1_type;

   logic        adv;
   logic        v1_ff, v2_ff, v3_ff;
   s1_type      s1_ff, s1_in;
   logic [7:0]  c2_ff, c2_in;
   logic [7:0]  c3_ff;
   logic [31:0] w;

   // The whole pipeline moves when the output is empty or being taken.
   assign adv       = !v3_ff || rsp_ready;
   assign req_ready = adv;
   assign w         = req_instruction_word;

   // Stage 1: field extract and table lookups (bit 0 is the MSB).
   always_comb begin
      s1_in.op     = w[31:26];
      s1_in.prim   = ricd_pkg::primary_class(w[31:26]);
      s1_in.g19    = ricd_pkg::g19_index(w[10:1]);
      s1_in.rld_lo = w[4:2];
      s1_in.rld_hi = w[4:1];
      s1_in.dcbt   = (w[10:1] == ricd_pkg::XO_DCBT) || (w[10:1] == ricd_pkg::XO_DCBT_ALT);
      s1_in.g31a   = ricd_pkg::g31a_index(w[10:1]);
      s1_in.g31b   = ricd_pkg::g31b_index(w[9:1]);
      s1_in.sradix = (w[10:2] == ricd_pkg::XO_SRADIX);
      s1_in.low2   = w[1:0];
   end

   // Stage 2: select the class by primary opcode and group priority.
   always_comb begin
      c2_in = ricd_pkg::CLS_INVALID;
      case (s1_ff.op)
         ricd_pkg::OP_G19: begin
            if (s1_ff.g19 != 8'd0) c2_in = ricd_pkg::CLS_G19_BASE + s1_ff.g19 - 8'd1;
         end
         ricd_pkg::OP_G30: begin
            if (s1_ff.rld_lo <= 3'd3) c2_in = ricd_pkg::CLS_RLD_BASE + {5'd0, s1_ff.rld_lo};
            else if (s1_ff.rld_hi == 4'd8) c2_in = ricd_pkg::CLS_RLD_BASE + 8'd4;
            else if (s1_ff.rld_hi == 4'd9) c2_in = ricd_pkg::CLS_RLD_BASE + 8'd5;
         end
         ricd_pkg::OP_G31: begin
            if (s1_ff.dcbt) c2_in = ricd_pkg::CLS_DCBT;
            else if (s1_ff.g31a != 7'd0)
               c2_in = ricd_pkg::CLS_G31A_BASE + {1'b0, s1_ff.g31a} - 8'd1;
            else if (s1_ff.g31b != 5'd0)
               c2_in = ricd_pkg::CLS_G31B_BASE + {3'd0, s1_ff.g31b} - 8'd1;
            else if (s1_ff.sradix) c2_in = ricd_pkg::CLS_SRADIX;
         end
         ricd_pkg::OP_G58: begin
            if (s1_ff.low2 <= 2'd2) c2_in = ricd_pkg::CLS_G58_BASE + {6'd0, s1_ff.low2};
         end
         ricd_pkg::OP_G62: begin
            if (s1_ff.low2 <= 2'd1) c2_in = ricd_pkg::CLS_G62_BASE + {6'd0, s1_ff.low2};
         end
         default: c2_in = s1_ff.prim;
      endcase
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         c2_ff <= c2_in;
         c3_ff <= c2_ff;
      end
   end

   assign rsp_valid       = v3_ff;
   assign rsp_instr_class = c3_ff;
   assign rsp_is_invalid  = (c3_ff == ricd_pkg::CLS_INVALID);

endmodule

/* sim/risc_instruction_class_decoder_core_tb.sv */
// ============================================================================
// risc_instruction_class_decoder_core_tb
// Drives instruction words through the class decoder with random gaps and
// output stalls, predicts each class code, and checks the responses in order.
// ============================================================================
module risc_instruction_class_decoder_core_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_instruction_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_instr_class;
   logic        rsp_is_invalid;

   typedef struct packed {
      logic [7:0] instr_class;
      logic       is_invalid;
   } decode_type;

   logic [31:0] pending_words[$];
   decode_type  expected_decodes[$];
   int          error_count = 0;
   bit          stimulus_done = 0;
   int          hold_cycles = 0;
   bit          req_taken = 0;

   risc_instruction_class_decoder_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_instruction_word(req_instruction_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_instr_class(rsp_instr_class),
      .rsp_is_invalid(rsp_is_invalid)
   );

   // Clock generation.
   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Bit field of the word, bits numbered from the MSB.
   function automatic logic [31:0] bits_of(input logic [31:0] w, input int first,
                                           input int last);
      return (w >> (31 - last)) & ((32'd1 << (last - first + 1)) - 1);
   endfunction

   // Predicts the class of one instruction word.
   function automatic decode_type predict_class(input logic [31:0] w);
      logic [7:0] primary_tab[64];
      int         g19_tab[13];
      int         g31a_tab[94];
      int         g31b_tab[21];
      logic [31:0] op;
      logic [31:0] xo;
      int          c;
      decode_type  d;
      primary_tab = '{0, 0, 1, 2, 0, 0, 0, 3, 4, 0, 5, 6, 7, 8, 9, 10,
                      11, 12, 13, 0, 27, 28, 0, 29, 30, 31, 32, 33, 34, 35, 0, 0,
                      159, 160, 161, 162, 163, 164, 165, 166,
                      167, 168, 169, 170, 171, 172, 0, 0,
                      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      g19_tab = '{0, 16, 18, 33, 129, 150, 193, 225, 257, 289, 417, 449, 528};
      g31a_tab = '{0, 4, 19, 20, 21, 23, 24, 26, 27, 28,
                   32, 53, 54, 55, 58, 60, 68, 83, 84, 86,
                   87, 119, 124, 144, 146, 149, 150, 151, 178, 181,
                   183, 210, 214, 215, 242, 247, 279, 284, 274, 306,
                   310, 311, 316, 339, 341, 343, 370, 371, 373, 375,
                   407, 412, 434, 438, 439, 444, 467, 476, 498, 533,
                   534, 535, 536, 539, 566, 567, 595, 597, 598, 599,
                   631, 569, 915, 851, 402, 661, 662, 663, 695, 725,
                   727, 759, 790, 762, 794, 824, 854, 918, 922, 954,
                   982, 983, 986, 1014};
      g31b_tab = '{8, 9, 10, 11, 40, 73, 75, 104, 136, 138, 200,
                   202, 232, 233, 234, 235, 266, 457, 459, 489, 491};
      op = bits_of(w, 0, 5);
      c = ricd_pkg::CLS_INVALID;
      case (op[5:0])
         ricd_pkg::OP_G19: begin
            xo = bits_of(w, 21, 30);
            for (int i = 12; i >= 0; i--)
               if (xo == g19_tab[i]) c = ricd_pkg::CLS_G19_BASE + i;
         end
         ricd_pkg::OP_G30: begin
            xo = bits_of(w, 27, 29);
            if (xo <= 3) c = ricd_pkg::CLS_RLD_BASE + xo;
            else begin
               xo = bits_of(w, 27, 30);
               if (xo == 8 || xo == 9) c = ricd_pkg::CLS_RLD_BASE + 4 + (xo - 8);
            end
         end
         ricd_pkg::OP_G31: begin
            xo = bits_of(w, 21, 30);
            if (xo == ricd_pkg::XO_DCBT || xo == ricd_pkg::XO_DCBT_ALT)
               c = ricd_pkg::CLS_DCBT;
            else begin
               for (int i = 93; i >= 0; i--)
                  if (xo == g31a_tab[i]) c = ricd_pkg::CLS_G31A_BASE + i;
               if (c == ricd_pkg::CLS_INVALID) begin
                  xo = bits_of(w, 22, 30);
                  for (int i = 20; i >= 0; i--)
                     if (xo == g31b_tab[i]) c = ricd_pkg::CLS_G31B_BASE + i;
               end
               if (c == ricd_pkg::CLS_INVALID && bits_of(w, 21, 29) == ricd_pkg::XO_SRADIX)
                  c = ricd_pkg::CLS_SRADIX;
            end
         end
         ricd_pkg::OP_G58: begin
            xo = bits_of(w, 30, 31);
            if (xo <= 2) c = ricd_pkg::CLS_G58_BASE + xo;
         end
         ricd_pkg::OP_G62: begin
            xo = bits_of(w, 30, 31);
            if (xo <= 1) c = ricd_pkg::CLS_G62_BASE + xo;
         end
         default: c = primary_tab[op];
      endcase
      d.instr_class = c[7:0];
      d.is_invalid = (c == ricd_pkg::CLS_INVALID);
      return d;
   endfunction

   // Builds a word from an opcode, an extended opcode placed at bit 'last', and noise.
   function automatic logic [31:0] make_word(input logic [5:0] op, input int xo,
                                             input int last, input logic [31:0] noise);
      logic [31:0] w;
      w = noise;
      w[31:26] = op;
      if (last >= 0) w = w & ~(32'h3FF << (31 - last)) | (xo << (31 - last));
      return w;
   endfunction

   // Random gap length: mostly short, sometimes long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(3);
      return $urandom_range(30, 10);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Stimulus: directed corners, then mostly well-formed random words.
   initial begin
      int kind;
      logic [31:0] noise;
      pending_words.push_back(32'h0000_0000);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(32'h5555_5555);
      pending_words.push_back(32'hAAAA_AAAA);
      pending_words.push_back(make_word(ricd_pkg::OP_G31, 278, 30, 0));
      pending_words.push_back(make_word(ricd_pkg::OP_G31, 246, 30, 32'hFFFF_FFFF));
      pending_words.push_back(make_word(ricd_pkg::OP_G31, 1014, 30, 0));
      pending_words.push_back(make_word(ricd_pkg::OP_G31, 413 << 1, 30, 1));
      pending_words.push_back(make_word(ricd_pkg::OP_G31, 266, 30, 0));
      pending_words.push_back(make_word(ricd_pkg::OP_G31, 266 | 512, 30, 0));
      pending_words.push_back(make_word(ricd_pkg::OP_G19, 528, 30, 32'h0000_0800));
      pending_words.push_back(make_word(ricd_pkg::OP_G19, 0, 30, 32'hFFFF_FFFF));
      pending_words.push_back(make_word(ricd_pkg::OP_G30, 9, 30, 0));
      pending_words.push_back(make_word(ricd_pkg::OP_G30, 3 << 1, 30, 1));
      pending_words.push_back(make_word(ricd_pkg::OP_G30, 15, 30, 0));
      for (int k = 0; k < 4; k++) begin
         pending_words.push_back(make_word(ricd_pkg::OP_G58, k, 31, 0));
         pending_words.push_back(make_word(ricd_pkg::OP_G62, k, 31, 32'hFFFF_FFFF));
      end
      for (int i = 0; i < 500; i++) begin
         noise = $urandom;
         kind = $urandom_range(9);
         case (kind)
            0: pending_words.push_back(make_word(ricd_pkg::OP_G19, $urandom_range(1023), 30,
                                                 noise));
            1: pending_words.push_back(make_word(ricd_pkg::OP_G30, $urandom_range(15), 30,
                                                 noise));
            2, 3, 4: pending_words.push_back(make_word(ricd_pkg::OP_G31,
                                                       $urandom_range(1023), 30, noise));
            5: pending_words.push_back(make_word(ricd_pkg::OP_G58, $urandom_range(3), 31,
                                                 noise));
            6: pending_words.push_back(make_word(ricd_pkg::OP_G62, $urandom_range(3), 31,
                                                 noise));
            7: pending_words.push_back(make_word(6'($urandom_range(45)), 0, -1, noise));
            default: pending_words.push_back(noise);
         endcase
      end
   end

   // Reset, then wait for the last response and let the pipeline drain.
   initial begin
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      wait (stimulus_done && expected_decodes.size() == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("** risc_instruction_class_decoder_core: PASSED **");
      else
         $display("** risc_instruction_class_decoder_core: FAILED **");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("** risc_instruction_class_decoder_core: FAILED **");
      $finish;
   end

   // Request driver: changes at the falling edge. Acceptance is taken from the
   // flag that the monitor sets at the rising edge.
   int req_gap = 0;
   initial begin
      req_valid = 0;
      req_instruction_word = '0;
   end
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) req_gap = gap_len();
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 0;
            end else if (pending_words.size() > 0) begin
               req_valid <= 1;
               req_instruction_word <= pending_words.pop_front();
            end else begin
               req_valid <= 0;
               stimulus_done = 1;
            end
         end
         req_taken = 0;
      end
   end

   // Response ready: random stalls, plus one long hold-off to back up the pipe.
   int rsp_gap = 0;
   int accepted_count = 0;
   initial rsp_ready = 0;
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if ($urandom_range(3) == 0) rsp_gap = gap_len();
      end
   end

   // Monitor: sample both handshakes at the rising edge.
   always @(posedge clock) begin
      decode_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_decodes.push_back(predict_class(req_instruction_word));
            req_taken = 1;
            accepted_count++;
            if (accepted_count == 100) hold_cycles = 40;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("response with no request outstanding", rsp_instr_class, 0);
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_instr_class !== want.instr_class)
                  report_mismatch("instr_class", rsp_instr_class, want.instr_class);
               if (rsp_is_invalid !== want.is_invalid)
                  report_mismatch("is_invalid", rsp_is_invalid, want.is_invalid);
            end
         end
      end
   end

endmodule
